@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the converter RTL.
// Depends on nothing; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// When the condition holds, the result must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ rtl/core/hslrgb_pkg.sv @@
// Types, constants and helpers for the HSL to RGB converter.
// Depends on nothing; every module of the converter imports it.
`timescale 1ns / 1ps

package hslrgb_pkg;

    // Field widths.
    localparam int HueW    = 9;
    localparam int PctW    = 7;
    localparam int ChanW   = 8;
    localparam int ChromaW = 6;
    localparam int RemW    = 6;

    // Color-space constants.
    localparam int PctFull   = 100;
    localparam int SectorDeg = 60;
    localparam int HueMax    = 6 * SectorDeg;

    // Arithmetic widths along the back pipeline.
    localparam int ScW    = 13;  // saturation times chroma, at most 5000
    localparam int XW     = 14;  // 100*L plus or minus S*C, at most 10000
    localparam int ScfW   = 19;  // S*C times the sector fraction, at most 300000
    localparam int NW     = 19;  // 51 times an X value
    localparam int NMidW  = 24;  // 17 times the interpolation numerator

    // 255/10000 reduces to 51/2000 and 255/600000 to 17/40000.
    localparam int TopNum = 51;
    localparam int TopDiv = 2000;
    localparam int MidNum = 17;
    localparam int MidDiv = 40000;

    // Reciprocals are rounded up; the shift is large enough that the
    // product floor is exact over the whole numerator range.
    localparam int TopShift  = 31;
    localparam int MidShift  = 39;
    localparam int TopRecipW = 21;
    localparam int MidRecipW = 24;
    localparam logic [TopRecipW-1:0] TopRecip =
        TopRecipW'(((64'd1 << TopShift) + TopDiv - 1) / TopDiv);
    localparam logic [MidRecipW-1:0] MidRecip =
        MidRecipW'(((64'd1 << MidShift) + MidDiv - 1) / MidDiv);
    localparam int PTopW = NW + TopRecipW;
    localparam int PMidW = NMidW + MidRecipW;

    // Queue between the front and the back.
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    typedef enum logic [2:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } sector_t;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic                black;
        sector_t             sector;
        logic [RemW-1:0]     rem;
        logic [PctW-1:0]     sat;
        logic [PctW-1:0]     light;
        logic [ChromaW-1:0]  chroma;
    } hslrgb_item_t;

    // Odd sectors interpolate on a falling slope.
    function automatic logic is_falling(input sector_t sec);
        logic res;
        begin
            case (sec)
                SEC_YELLOW_GREEN: res = 1'b1;
                SEC_CYAN_BLUE:    res = 1'b1;
                SEC_MAGENTA_RED:  res = 1'b1;
                default:          res = 1'b0;
            endcase
            return res;
        end
    endfunction

endpackage

@@ rtl/core/hslrgb_front.sv @@
// Front end: accepts HSL words, clamps the percentages and classifies the hue.
// Depends on hslrgb_pkg.
`timescale 1ns / 1ps

module hslrgb_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [8:0]                hue,
    input  logic [6:0]                saturation,
    input  logic [6:0]                lightness,
    output hslrgb_pkg::hslrgb_item_t  item,
    output logic                      item_valid,
    input  logic                      item_ready
);
    import hslrgb_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    hslrgb_item_t  item_reg;
    hslrgb_item_t  item_next;
    logic          load;
    logic [PctW-1:0] sat_c;
    logic [PctW-1:0] light_c;
    logic [HueW-1:0] base;

    assign full       = valid_reg && !item_ready;
    assign load       = push && !full;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    always_comb
    begin
        sat_c   = (saturation > PctW'(PctFull)) ? PctW'(PctFull) : saturation;
        light_c = (lightness > PctW'(PctFull)) ? PctW'(PctFull) : lightness;

        // A hue of exactly 360 wraps to the first sector with no fraction.
        if (hue >= HueW'(HueMax))
        begin
            item_next.sector = SEC_RED_YELLOW;
            base             = HueW'(HueMax);
        end
        else if (hue >= HueW'(5 * SectorDeg))
        begin
            item_next.sector = SEC_MAGENTA_RED;
            base             = HueW'(5 * SectorDeg);
        end
        else if (hue >= HueW'(4 * SectorDeg))
        begin
            item_next.sector = SEC_BLUE_MAGENTA;
            base             = HueW'(4 * SectorDeg);
        end
        else if (hue >= HueW'(3 * SectorDeg))
        begin
            item_next.sector = SEC_CYAN_BLUE;
            base             = HueW'(3 * SectorDeg);
        end
        else if (hue >= HueW'(2 * SectorDeg))
        begin
            item_next.sector = SEC_GREEN_CYAN;
            base             = HueW'(2 * SectorDeg);
        end
        else if (hue >= HueW'(SectorDeg))
        begin
            item_next.sector = SEC_YELLOW_GREEN;
            base             = HueW'(SectorDeg);
        end
        else
        begin
            item_next.sector = SEC_RED_YELLOW;
            base             = '0;
        end

        item_next.black = (hue > HueW'(HueMax));
        item_next.rem   = RemW'(hue - base);
        item_next.sat   = sat_c;
        item_next.light = light_c;
        if (light_c < PctW'(PctFull / 2))
        begin
            item_next.chroma = ChromaW'(light_c);
        end
        else
        begin
            item_next.chroma = ChromaW'(PctW'(PctFull) - light_c);
        end
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/core/hslrgb_queue.sv @@
// Short word queue that decouples the front end from the arithmetic back end.
// Depends on hslrgb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hslrgb_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  hslrgb_pkg::hslrgb_item_t  in_item,
    output logic                      in_ready,
    output logic                      out_valid,
    output hslrgb_pkg::hslrgb_item_t  out_item,
    input  logic                      out_ready
);
    import hslrgb_pkg::*;

    hslrgb_item_t          mem [QueueDepth];
    logic [QueuePtrW-1:0]  wr_ptr_reg;
    logic [QueuePtrW-1:0]  rd_ptr_reg;
    logic [QueueCntW-1:0]  count_reg;
    logic [QueueCntW-1:0]  count_next;
    logic                  wr;
    logic                  rd;

    assign in_ready  = (count_reg != QueueCntW'(QueueDepth));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= QueueCntW'(QueueDepth))
    `ASSERT_NEXT(a_count_fill, clk, rst_n, wr && !rd, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ rtl/core/hslrgb_back.sv @@
// Back end: five-stage arithmetic pipeline from classified words to RGB words.
// Depends on hslrgb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hslrgb_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  hslrgb_pkg::hslrgb_item_t  in_item,
    output logic                      in_ready,
    input  logic                      pop,
    output logic                      empty,
    output logic [7:0]                red,
    output logic [7:0]                green,
    output logic [7:0]                blue
);
    import hslrgb_pkg::*;

    logic en;

    // Stage 1: S*C and the sector fraction.
    logic               v1_reg;
    logic [ScW-1:0]     s1_sc_reg;
    logic [PctW-1:0]    s1_light_reg;
    logic [RemW-1:0]    s1_frac_reg;
    sector_t            s1_sector_reg;
    logic               s1_black_reg;
    logic [RemW-1:0]    s1_frac_next;

    // Stage 2: 100*L plus and minus S*C, and S*C times the fraction.
    logic               v2_reg;
    logic [XW-1:0]      s2_xtop_reg;
    logic [XW-1:0]      s2_xbot_reg;
    logic [ScfW-1:0]    s2_scf_reg;
    sector_t            s2_sector_reg;
    logic               s2_black_reg;
    logic [XW-1:0]      hundred_l;

    // Stage 3: numerators over the reduced divisors.
    logic               v3_reg;
    logic [NW-1:0]      s3_ntop_reg;
    logic [NW-1:0]      s3_nbot_reg;
    logic [NMidW-1:0]   s3_nmid_reg;
    sector_t            s3_sector_reg;
    logic               s3_black_reg;

    // Stage 4: products with the reciprocals.
    logic               v4_reg;
    logic [PTopW-1:0]   s4_ptop_reg;
    logic [PTopW-1:0]   s4_pbot_reg;
    logic [PMidW-1:0]   s4_pmid_reg;
    sector_t            s4_sector_reg;
    logic               s4_black_reg;

    // Stage 5: routed channels, held for the consumer.
    logic               v5_reg;
    logic [ChanW-1:0]   red_reg;
    logic [ChanW-1:0]   green_reg;
    logic [ChanW-1:0]   blue_reg;
    logic [ChanW-1:0]   red_next;
    logic [ChanW-1:0]   green_next;
    logic [ChanW-1:0]   blue_next;
    logic [ChanW-1:0]   q_top;
    logic [ChanW-1:0]   q_bot;
    logic [ChanW-1:0]   q_mid;

    // The whole pipeline moves together whenever the output word can leave.
    assign en       = !v5_reg || pop;
    assign in_ready = en;
    assign empty    = !v5_reg;
    assign red      = red_reg;
    assign green    = green_reg;
    assign blue     = blue_reg;

    assign s1_frac_next = is_falling(in_item.sector)
                        ? RemW'(RemW'(SectorDeg) - in_item.rem) : in_item.rem;
    assign hundred_l    = XW'(s1_light_reg) * XW'(PctFull);

    assign q_top = s4_ptop_reg[TopShift +: ChanW];
    assign q_bot = s4_pbot_reg[TopShift +: ChanW];
    assign q_mid = s4_pmid_reg[MidShift +: ChanW];

    always_comb
    begin
        case (s4_sector_reg)
            SEC_YELLOW_GREEN:
            begin
                red_next = q_mid;  green_next = q_top;  blue_next = q_bot;
            end
            SEC_GREEN_CYAN:
            begin
                red_next = q_bot;  green_next = q_top;  blue_next = q_mid;
            end
            SEC_CYAN_BLUE:
            begin
                red_next = q_bot;  green_next = q_mid;  blue_next = q_top;
            end
            SEC_BLUE_MAGENTA:
            begin
                red_next = q_mid;  green_next = q_bot;  blue_next = q_top;
            end
            SEC_MAGENTA_RED:
            begin
                red_next = q_top;  green_next = q_bot;  blue_next = q_mid;
            end
            default:
            begin
                red_next = q_top;  green_next = q_mid;  blue_next = q_bot;
            end
        endcase
        if (s4_black_reg)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sc_reg     <= ScW'(in_item.sat) * ScW'(in_item.chroma);
            s1_light_reg  <= in_item.light;
            s1_frac_reg   <= s1_frac_next;
            s1_sector_reg <= in_item.sector;
            s1_black_reg  <= in_item.black;

            s2_xtop_reg   <= hundred_l + XW'(s1_sc_reg);
            s2_xbot_reg   <= hundred_l - XW'(s1_sc_reg);
            s2_scf_reg    <= ScfW'(s1_sc_reg) * ScfW'(s1_frac_reg);
            s2_sector_reg <= s1_sector_reg;
            s2_black_reg  <= s1_black_reg;

            s3_ntop_reg   <= NW'(s2_xtop_reg) * NW'(TopNum);
            s3_nbot_reg   <= NW'(s2_xbot_reg) * NW'(TopNum);
            s3_nmid_reg   <= NMidW'(s2_xbot_reg) * NMidW'(MidNum * SectorDeg)
                           + NMidW'(s2_scf_reg) * NMidW'(MidNum * 2);
            s3_sector_reg <= s2_sector_reg;
            s3_black_reg  <= s2_black_reg;

            s4_ptop_reg   <= PTopW'(s3_ntop_reg) * PTopW'(TopRecip);
            s4_pbot_reg   <= PTopW'(s3_nbot_reg) * PTopW'(TopRecip);
            s4_pmid_reg   <= PMidW'(s3_nmid_reg) * PMidW'(MidRecip);
            s4_sector_reg <= s3_sector_reg;
            s4_black_reg  <= s3_black_reg;

            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
        end
    end

    `ASSERT_NEXT(a_stage_advance, clk, rst_n, en && v4_reg, v5_reg)
    `ASSERT_NEXT(a_black_zero, clk, rst_n, en && v4_reg && s4_black_reg, red_reg == '0 && green_reg == '0 && blue_reg == '0)

endmodule

@@ rtl/core/hsl_to_rgb_converter.sv @@
// Top level of the HSL to RGB converter: front end, queue and back end.
// Depends on hslrgb_pkg, hslrgb_front, hslrgb_queue and hslrgb_back.
//
//   Channel   Direction  Handshake      Fields
//   input     in         push / full    hue[8:0], saturation[6:0], lightness[6:0]
//   result    out        pop / empty    red[7:0], green[7:0], blue[7:0]
//
// One word is accepted and one result delivered per clock when pop stays high.
// An accepted word passes the front register, which loads at the accepting edge,
// then one queue slot and then the five back-end stages before its result appears.
// Reset clears only control state; the block takes words right after reset.
// With pop low the back end holds once a result waits; the four-word queue and
// front register absorb the backlog before full rises.
`timescale 1ns / 1ps

module hsl_to_rgb_converter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [8:0] hue,
    input  logic [6:0] saturation,
    input  logic [6:0] lightness,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);
    import hslrgb_pkg::*;

    hslrgb_item_t  front_item;
    logic          front_valid;
    logic          front_ready;
    hslrgb_item_t  queue_item;
    logic          queue_valid;
    logic          back_ready;

    hslrgb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    hslrgb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .in_ready  (front_ready),
        .out_valid (queue_valid),
        .out_item  (queue_item),
        .out_ready (back_ready)
    );

    hslrgb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (queue_valid),
        .in_item  (queue_item),
        .in_ready (back_ready),
        .pop      (pop),
        .empty    (empty),
        .red      (red),
        .green    (green),
        .blue     (blue)
    );

endmodule
